// ===== sv/dcam_pkg.sv =====
package dcam_pkg;

  localparam int MAP_DEPTH_DEF = 64;
  localparam int ADDR_BITS     = 32;
  localparam int DELTA_BITS    = 8;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_BACKWARDS = 3'd2,
    ST_DELTA     = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  typedef enum logic {
    REQ_APPEND = 1'b0,
    REQ_FIND   = 1'b1
  } req_type_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_WALK,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic init;
    logic step;
  } walk_ctl_t;

  typedef struct packed {
    logic                  hit;
    logic                  over;
    logic [ADDR_BITS-1:0]  offset;
  } walk_res_t;

endpackage

// ===== sv/dcam_req_if.sv =====
interface dcam_req_if;
  logic                           valid;
  logic                           ready;
  logic                           req_type;
  logic [dcam_pkg::ADDR_BITS-1:0] guest_address;
  logic [dcam_pkg::ADDR_BITS-1:0] native_offset;

  modport source (output valid, output req_type, output guest_address,
                  output native_offset, input ready);
  modport sink (input valid, input req_type, input guest_address,
                input native_offset, output ready);
endinterface

// ===== sv/dcam_rsp_if.sv =====
interface dcam_rsp_if;
  logic                           valid;
  logic                           ready;
  dcam_pkg::status_t              status;
  logic [dcam_pkg::ADDR_BITS-1:0] found_offset;

  modport source (output valid, output status, output found_offset, input ready);
  modport sink (input valid, input status, input found_offset, output ready);
endinterface

// ===== sv/dcam_cfg_if.sv =====
interface dcam_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [dcam_pkg::ADDR_BITS-1:0] start_address;

  modport source (output valid, output start_address, input ready);
  modport sink (input valid, input start_address, output ready);
endinterface

// ===== sv/delta_coded_address_map.sv =====
// Channel  Dir  Payload                                      Transfer
// cfg      in   start_address[31:0]                          valid & ready
// req      in   req_type, guest_address[31:0], native_offset valid & ready
// rsp      out  status[2:0], found_offset[31:0]              valid & ready
//
// Append: checked in S_EXEC, result registered and passed to rsp from S_RESULT.
// Find: S_EXEC, then S_WALK reads the entry memory one word per cycle and sums
//   the deltas in dcam_walk until a hit, an overshoot or the last stored entry.
// One request at a time; req.ready is high only between requests.
// A stalled result holds in rsp; the next request is taken meanwhile.
// Synchronous reset empties the map and sets start address to zero.
module delta_coded_address_map #(
  parameter int MAP_DEPTH = dcam_pkg::MAP_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  dcam_cfg_if.sink         cfg,
  dcam_req_if.sink         req,
  dcam_rsp_if.source       rsp
);

  localparam int AW     = dcam_pkg::ADDR_BITS;
  localparam int DW     = dcam_pkg::DELTA_BITS;
  localparam int ADDR_W = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
  localparam int CNT_W  = $clog2(MAP_DEPTH + 1);

  dcam_pkg::state_t state, state_next;

  logic [AW-1:0]    start_address;
  logic [AW-1:0]    last_address;
  logic [AW-1:0]    last_offset;
  logic [CNT_W-1:0] entry_count;
  logic [CNT_W-1:0] idx;

  dcam_pkg::req_type_t req_kind;
  logic [AW-1:0]       req_addr;
  logic [AW-1:0]       req_ofs;

  dcam_pkg::status_t res_status;
  logic [AW-1:0]     res_offset;

  logic              done;
  dcam_pkg::status_t done_status;
  logic [AW-1:0]     done_offset;
  logic              advance;
  logic              mem_we;
  logic              req_xfer;
  logic              out_free;

  logic [AW-1:0]     delta_addr;
  logic [AW-1:0]     delta_ofs;
  logic              backwards;
  logic              delta_big;
  logic              full;
  logic              out_range;
  logic [2*DW-1:0]   entry;

  dcam_pkg::walk_ctl_t wctl;
  dcam_pkg::walk_res_t wres;

  assign req_xfer  = req.valid && req.ready;
  assign out_free  = !rsp.valid || rsp.ready;
  assign cfg.ready = (state == dcam_pkg::S_IDLE);

  assign backwards  = (req_addr < last_address) || (req_ofs < last_offset);
  assign delta_addr = req_addr - last_address;
  assign delta_ofs  = req_ofs - last_offset;
  assign delta_big  = (|delta_addr[AW-1:DW]) || (|delta_ofs[AW-1:DW]);
  assign full       = (entry_count == CNT_W'(MAP_DEPTH));
  assign out_range  = (req_addr < start_address) || (req_addr > last_address);

  dcam_ram #(
    .DEPTH  (MAP_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (entry_count[ADDR_W-1:0]),
    .wdata ({delta_ofs[DW-1:0], delta_addr[DW-1:0]}),
    .raddr (idx[ADDR_W-1:0]),
    .rdata (entry)
  );

  dcam_walk u_walk (
    .clk           (clk),
    .ctl           (wctl),
    .start_address (start_address),
    .target        (req_addr),
    .entry         (entry),
    .res           (wres)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      dcam_pkg::S_IDLE:   if (req_xfer) state_next = dcam_pkg::S_EXEC;
      dcam_pkg::S_EXEC:   state_next = done ? dcam_pkg::S_RESULT : dcam_pkg::S_WALK;
      dcam_pkg::S_WALK:   if (done) state_next = dcam_pkg::S_RESULT;
      dcam_pkg::S_RESULT: if (out_free) state_next = dcam_pkg::S_IDLE;
      default:            state_next = dcam_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    req.ready   = 1'b0;
    mem_we      = 1'b0;
    wctl        = '0;
    done        = 1'b0;
    done_status = dcam_pkg::ST_OK;
    done_offset = '0;
    advance     = 1'b0;
    unique case (state)
      dcam_pkg::S_IDLE: begin
        req.ready = 1'b1;
      end
      dcam_pkg::S_EXEC: begin
        if (req_kind == dcam_pkg::REQ_APPEND) begin
          done = 1'b1;
          priority if (backwards) begin
            done_status = dcam_pkg::ST_BACKWARDS;
          end else if (delta_big) begin
            done_status = dcam_pkg::ST_DELTA;
          end else if (full) begin
            done_status = dcam_pkg::ST_FULL;
          end else begin
            done_status = dcam_pkg::ST_OK;
            mem_we      = 1'b1;
          end
        end else if (out_range || (entry_count == '0)) begin
          done        = 1'b1;
          done_status = dcam_pkg::ST_NOT_FOUND;
        end else begin
          wctl.init = 1'b1;
          advance   = 1'b1;
        end
      end
      dcam_pkg::S_WALK: begin
        wctl.step = 1'b1;
        priority if (wres.hit) begin
          done        = 1'b1;
          done_status = dcam_pkg::ST_OK;
          done_offset = wres.offset;
        end else if (wres.over || (idx == entry_count)) begin
          done        = 1'b1;
          done_status = dcam_pkg::ST_NOT_FOUND;
        end else begin
          advance = 1'b1;
        end
      end
      dcam_pkg::S_RESULT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= dcam_pkg::S_IDLE;
      start_address <= '0;
      last_address  <= '0;
      last_offset   <= '0;
      entry_count   <= '0;
      rsp.valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg.valid && cfg.ready) begin
        start_address <= cfg.start_address;
        last_address  <= cfg.start_address;
        last_offset   <= '0;
        entry_count   <= '0;
      end else if (mem_we) begin
        last_address <= req_addr;
        last_offset  <= req_ofs;
        entry_count  <= entry_count + CNT_W'(1);
      end
      if (state == dcam_pkg::S_RESULT && out_free) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_xfer) begin
      req_kind <= dcam_pkg::req_type_t'(req.req_type);
      req_addr <= req.guest_address;
      req_ofs  <= req.native_offset;
      idx      <= '0;
    end else if (advance) begin
      idx <= idx + CNT_W'(1);
    end
    if (done) begin
      res_status <= done_status;
      res_offset <= done_offset;
    end
    if (state == dcam_pkg::S_RESULT && out_free) begin
      rsp.status       <= res_status;
      rsp.found_offset <= res_offset;
    end
  end

endmodule

// ===== sv/dcam_ram.sv =====
module dcam_ram #(
  parameter int DEPTH  = dcam_pkg::MAP_DEPTH_DEF,
  parameter int ADDR_W = 6
) (
  input  logic                            clk,
  input  logic                            we,
  input  logic [ADDR_W-1:0]               waddr,
  input  logic [2*dcam_pkg::DELTA_BITS-1:0] wdata,
  input  logic [ADDR_W-1:0]               raddr,
  output logic [2*dcam_pkg::DELTA_BITS-1:0] rdata
);

  logic [2*dcam_pkg::DELTA_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/dcam_walk.sv =====
module dcam_walk (
  input  logic                                clk,
  input  dcam_pkg::walk_ctl_t                 ctl,
  input  logic [dcam_pkg::ADDR_BITS-1:0]      start_address,
  input  logic [dcam_pkg::ADDR_BITS-1:0]      target,
  input  logic [2*dcam_pkg::DELTA_BITS-1:0]   entry,
  output dcam_pkg::walk_res_t                 res
);

  localparam int AW = dcam_pkg::ADDR_BITS;
  localparam int DW = dcam_pkg::DELTA_BITS;

  logic [AW-1:0] acc_addr;
  logic [AW-1:0] acc_ofs;
  logic [AW-1:0] sum_addr;
  logic [AW-1:0] sum_ofs;

  assign sum_addr = acc_addr + {{(AW-DW){1'b0}}, entry[DW-1:0]};
  assign sum_ofs  = acc_ofs + {{(AW-DW){1'b0}}, entry[2*DW-1:DW]};

  assign res.hit    = (sum_addr == target);
  assign res.over   = (sum_addr > target);
  assign res.offset = sum_ofs;

  always_ff @(posedge clk) begin
    if (ctl.init) begin
      acc_addr <= start_address;
      acc_ofs  <= '0;
    end else if (ctl.step) begin
      acc_addr <= sum_addr;
      acc_ofs  <= sum_ofs;
    end
  end

endmodule

// ===== sv/dcam_chk.sv =====
module dcam_chk (
  input logic                           clk,
  input logic                           rst,
  input logic                           req_valid,
  input logic                           req_ready,
  input logic                           rsp_valid,
  input logic                           rsp_ready,
  input dcam_pkg::status_t              rsp_status,
  input logic [dcam_pkg::ADDR_BITS-1:0] rsp_found_offset
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result dropped while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while busy");

  a_offset_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status != dcam_pkg::ST_OK) |-> (rsp_found_offset == '0))
    else $error("nonzero offset on failed request");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid after reset");

endmodule

bind delta_coded_address_map dcam_chk u_dcam_chk (
  .clk              (clk),
  .rst              (rst),
  .req_valid        (req.valid),
  .req_ready        (req.ready),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_status       (rsp.status),
  .rsp_found_offset (rsp.found_offset)
);
